>>> sv/vlmr_pkg.sv
// Shared types and constants of the variable-length message ring.
`default_nettype none
package vlmr_pkg;

   // Header layout and limits
   localparam int HEAD_BYTES      = 24;
   localparam int HDR_FIELD_BYTES = 15;
   localparam int MAX_PAYLOAD     = 63;
   localparam int MIN_QUEUE       = 64;
   localparam logic [7:0] MAX_COUNT = 8'd255;

   // Operation codes
   localparam logic [2:0] OP_APPEND  = 3'd0;
   localparam logic [2:0] OP_URGENT  = 3'd1;
   localparam logic [2:0] OP_PAYLOAD = 3'd2;
   localparam logic [2:0] OP_PEEK    = 3'd3;
   localparam logic [2:0] OP_READ    = 3'd4;
   localparam logic [2:0] OP_REMOVE  = 3'd5;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_SIZE     = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   // What the captured word asks the datapath to do
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_PAYLOAD,
      ACT_HEADER,
      ACT_PEEK,
      ACT_READ,
      ACT_REMOVE
   } act_type;

   typedef struct packed {
      logic       capture;
      logic       hdr_accept;
      logic       hw_step;
      logic       pay_write;
      logic       hr_start;
      logic       hr_step;
      logic       remove;
      logic       read_begin;
      logic       pr_step;
      logic       read_end;
      logic       emit;
      logic [1:0] emit_status;
      logic       emit_head;
      logic       emit_pay;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      act_type    act;
      logic [1:0] code;
      logic       slot_free;
      logic       idx_last;
      logic       size_err;
      logic       pay_done;
      logic       hlen_zero;
   } sts_type;

endpackage
`default_nettype wire

>>> sv/variable_length_message_ring_core.sv
// Top level of the variable-length message ring.
// A header write stores the 15 header bytes in the ring before its result word.
// Peek, remove and read first fetch the 15 header bytes one a cycle.
// A read then delivers the payload words one at a time; a stalled result word holds the block.
// One word is worked on at a time; the next is accepted once the last result is registered.
// Synchronous active-high reset empties the queue and sets the ring size to BUF_BYTES.
`default_nettype none
module variable_length_message_ring_core #(
   parameter int BUF_BYTES = 4096
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // sender_id[15:0], message_id[47:16], stamp[111:48], length[117:112],
   // data_byte[125:118], max_length[131:126], zero fill[135:132]
   input  wire logic [135:0] req_tdata,
   // op[2:0]
   input  wire logic [2:0]   req_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [12:0]  csr_data,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0], remaining[9:2], out_sender[25:10], out_message_id[57:26],
   // out_stamp[121:58], out_length[127:122], out_byte[135:128]
   output logic [135:0]      rsp_tdata,
   // is_payload[0]
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   vlmr_pkg::cmd_type cmd;
   vlmr_pkg::sts_type sts;

   logic [1:0]  out_status;
   logic [7:0]  out_remaining;
   logic [15:0] out_sender;
   logic [31:0] out_message_id;
   logic [63:0] out_stamp;
   logic [5:0]  out_length;
   logic [7:0]  out_byte;

   assign csr_ready = 1'b1;

   vlmr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   vlmr_dpath #(
      .BUF_BYTES (BUF_BYTES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .in_op          (req_tuser),
      .in_sender_id   (req_tdata[15:0]),
      .in_message_id  (req_tdata[47:16]),
      .in_stamp       (req_tdata[111:48]),
      .in_length      (req_tdata[117:112]),
      .in_data_byte   (req_tdata[125:118]),
      .in_max_length  (req_tdata[131:126]),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .out_status     (out_status),
      .out_remaining  (out_remaining),
      .out_sender     (out_sender),
      .out_message_id (out_message_id),
      .out_stamp      (out_stamp),
      .out_length     (out_length),
      .out_byte       (out_byte),
      .out_is_payload (rsp_tuser),
      .out_last       (rsp_tlast)
   );

   // Result word packing
   assign rsp_tdata = {out_byte, out_length, out_stamp, out_message_id,
                       out_sender, out_remaining, out_status};

endmodule
`default_nettype wire

>>> sv/vlmr_ctrl.sv
// Controller state machine of the variable-length message ring.
`default_nettype none
module vlmr_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire vlmr_pkg::sts_type sts,
   output vlmr_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_EVAL, S_HWR, S_HRD, S_HWAIT, S_HEVAL,
      S_EMIT, S_EMIT_HEAD, S_RHEAD, S_PADDR, S_PDATA
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] code_ff, code_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            case (sts.act)
               vlmr_pkg::ACT_NONE: begin
                  code_in  = sts.code;
                  state_in = S_EMIT;
               end
               vlmr_pkg::ACT_PAYLOAD: begin
                  cmd.pay_write = 1'b1;
                  code_in       = vlmr_pkg::ST_OK;
                  state_in      = S_EMIT;
               end
               vlmr_pkg::ACT_HEADER: begin
                  cmd.hdr_accept = 1'b1;
                  code_in        = vlmr_pkg::ST_OK;
                  state_in       = S_HWR;
               end
               default: begin
                  cmd.hr_start = 1'b1;
                  state_in     = S_HRD;
               end
            endcase
         end
         S_HWR: begin
            cmd.hw_step = 1'b1;
            if (sts.idx_last) state_in = S_EMIT;
         end
         S_HRD: begin
            cmd.hr_step = 1'b1;
            if (sts.idx_last) state_in = S_HWAIT;
         end
         S_HWAIT: begin
            state_in = S_HEVAL;
         end
         S_HEVAL: begin
            code_in = vlmr_pkg::ST_OK;
            case (sts.act)
               vlmr_pkg::ACT_PEEK: begin
                  state_in = S_EMIT_HEAD;
               end
               vlmr_pkg::ACT_REMOVE: begin
                  cmd.remove = 1'b1;
                  state_in   = S_EMIT;
               end
               vlmr_pkg::ACT_READ: begin
                  if (sts.size_err) begin
                     code_in  = vlmr_pkg::ST_SIZE;
                     state_in = S_EMIT_HEAD;
                  end else begin
                     cmd.read_begin = 1'b1;
                     state_in       = S_RHEAD;
                  end
               end
               default: begin
                  state_in = S_EMIT;
               end
            endcase
         end
         S_EMIT: begin
            if (sts.slot_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = code_ff;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_EMIT_HEAD: begin
            if (sts.slot_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = code_ff;
               cmd.emit_head   = 1'b1;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_RHEAD: begin
            if (sts.slot_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = vlmr_pkg::ST_OK;
               cmd.emit_head   = 1'b1;
               cmd.emit_last   = sts.hlen_zero;
               state_in        = S_PADDR;
            end
         end
         S_PADDR: begin
            if (sts.pay_done) begin
               cmd.read_end = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.pr_step = 1'b1;
               state_in    = S_PDATA;
            end
         end
         S_PDATA: begin
            if (sts.slot_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_status = vlmr_pkg::ST_OK;
               cmd.emit_head   = 1'b1;
               cmd.emit_pay    = 1'b1;
               cmd.emit_last   = sts.pay_done;
               state_in        = S_PADDR;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered status code
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= vlmr_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule
`default_nettype wire

>>> sv/vlmr_dpath.sv
// Datapath of the variable-length message ring: pointers, ring memory, result register.
`default_nettype none
module vlmr_dpath #(
   parameter int BUF_BYTES = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire vlmr_pkg::cmd_type cmd,
   output vlmr_pkg::sts_type      sts,
   input  wire logic [2:0]        in_op,
   input  wire logic [15:0]       in_sender_id,
   input  wire logic [31:0]       in_message_id,
   input  wire logic [63:0]       in_stamp,
   input  wire logic [5:0]        in_length,
   input  wire logic [7:0]        in_data_byte,
   input  wire logic [5:0]        in_max_length,
   input  wire logic              csr_valid,
   input  wire logic [12:0]       csr_data,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [1:0]             out_status,
   output logic [7:0]             out_remaining,
   output logic [15:0]            out_sender,
   output logic [31:0]            out_message_id,
   output logic [63:0]            out_stamp,
   output logic [5:0]             out_length,
   output logic [7:0]             out_byte,
   output logic                   out_is_payload,
   output logic                   out_last
);

   localparam int PW = $clog2(BUF_BYTES);
   localparam int SW = PW + 2;

   // Queue state
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff, fill_ptr_ff, addr_ff;
   logic [PW:0]   qb_ff;
   logic [7:0]    count_ff;
   logic [5:0]    pend_ff;
   logic [5:0]    cnt_ff;
   logic          rd_pend_ff;
   logic [3:0]    rd_idx_ff;

   // Captured input word
   logic [2:0]  op_ff;
   logic [15:0] sender_ff;
   logic [31:0] mid_ff;
   logic [63:0] stamp_ff;
   logic [5:0]  len_ff;
   logic [7:0]  byte_ff;
   logic [5:0]  maxlen_ff;

   logic [7:0] ring_mem [BUF_BYTES];
   logic [7:0] mem_q;
   logic [7:0] hdr_ff [vlmr_pkg::HDR_FIELD_BYTES];
   logic       rsp_valid_ff;

   logic [SW-1:0] qb_s, w_s, r_s, need_s, free_s;
   logic [SW-1:0] wsum_s, wr_new_s, usum_s, urg_s, base_s;
   logic [SW-1:0] fsum_s, fill_new_s, ssum_s, start_s, asum_s, after_s;
   logic [SW-1:0] addr_inc_s, addr_next_s, fill_inc_s, fill_next_s;
   logic [5:0]    hlen;
   logic [119:0]  hdr_in;
   logic [7:0]    hdr_byte;
   logic          wr_en;
   logic [PW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          is_hdr_op;
   logic [31:0]   cfg_ext;
   logic [PW:0]   qb_cfg;
   vlmr_pkg::act_type act;
   logic [1:0]    code;

   // Ring arithmetic, every pointer sum wraps at the configured size
   always_comb begin
      qb_s   = SW'(qb_ff);
      w_s    = SW'(wr_ptr_ff);
      r_s    = SW'(rd_ptr_ff);
      need_s = SW'(vlmr_pkg::HEAD_BYTES) + SW'(len_ff);
      free_s = (r_s > w_s) ? (r_s - w_s) : (qb_s - (w_s - r_s));
      wsum_s   = w_s + need_s;
      wr_new_s = (wsum_s >= qb_s) ? (wsum_s - qb_s) : wsum_s;
      usum_s   = r_s + qb_s - need_s;
      urg_s    = (usum_s >= qb_s) ? (usum_s - qb_s) : usum_s;
      base_s   = (op_ff == vlmr_pkg::OP_URGENT) ? urg_s : w_s;
      fsum_s     = base_s + SW'(vlmr_pkg::HEAD_BYTES);
      fill_new_s = (fsum_s >= qb_s) ? (fsum_s - qb_s) : fsum_s;
      ssum_s  = r_s + SW'(vlmr_pkg::HEAD_BYTES);
      start_s = (ssum_s >= qb_s) ? (ssum_s - qb_s) : ssum_s;
      asum_s  = start_s + SW'(hlen);
      after_s = (asum_s >= qb_s) ? (asum_s - qb_s) : asum_s;
      addr_inc_s  = SW'(addr_ff) + SW'(1);
      addr_next_s = (addr_inc_s == qb_s) ? '0 : addr_inc_s;
      fill_inc_s  = SW'(fill_ptr_ff) + SW'(1);
      fill_next_s = (fill_inc_s == qb_s) ? '0 : fill_inc_s;
   end

   assign hlen   = hdr_ff[vlmr_pkg::HDR_FIELD_BYTES-1][5:0];
   assign hdr_in = {2'b00, len_ff, stamp_ff, mid_ff, sender_ff};
   assign hdr_byte = hdr_in[cnt_ff[3:0]*8 +: 8];
   assign is_hdr_op = (op_ff == vlmr_pkg::OP_APPEND) || (op_ff == vlmr_pkg::OP_URGENT);

   // Decode of the captured word against the queue state
   always_comb begin
      act  = vlmr_pkg::ACT_NONE;
      code = vlmr_pkg::ST_OK;
      if (op_ff == vlmr_pkg::OP_PAYLOAD) begin
         if (pend_ff == 6'd0) code = vlmr_pkg::ST_SIZE;
         else                 act  = vlmr_pkg::ACT_PAYLOAD;
      end else if (op_ff > vlmr_pkg::OP_REMOVE) begin
         code = vlmr_pkg::ST_OK;
      end else if (pend_ff != 6'd0) begin
         code = vlmr_pkg::ST_SIZE;
      end else if (is_hdr_op) begin
         if (32'(len_ff) > 32'(vlmr_pkg::MAX_PAYLOAD)) begin
            code = vlmr_pkg::ST_SIZE;
         end else if ((free_s <= need_s) || (count_ff >= vlmr_pkg::MAX_COUNT)) begin
            code = vlmr_pkg::ST_OVERFLOW;
         end else begin
            act = vlmr_pkg::ACT_HEADER;
         end
      end else if (count_ff == 8'd0) begin
         code = vlmr_pkg::ST_EMPTY;
      end else begin
         case (op_ff)
            vlmr_pkg::OP_PEEK: act = vlmr_pkg::ACT_PEEK;
            vlmr_pkg::OP_READ: act = vlmr_pkg::ACT_READ;
            default:           act = vlmr_pkg::ACT_REMOVE;
         endcase
      end
   end

   // Status towards the controller
   always_comb begin
      sts.act       = act;
      sts.code      = code;
      sts.slot_free = !rsp_valid_ff || rsp_ready;
      sts.idx_last  = (cnt_ff == 6'(vlmr_pkg::HDR_FIELD_BYTES - 1));
      sts.size_err  = (maxlen_ff < hlen);
      sts.pay_done  = (cnt_ff == hlen);
      sts.hlen_zero = (hlen == 6'd0);
   end

   // Clamp of the configured ring size
   assign cfg_ext = 32'(csr_data);
   always_comb begin
      if (cfg_ext < 32'(vlmr_pkg::MIN_QUEUE))  qb_cfg = (PW+1)'(vlmr_pkg::MIN_QUEUE);
      else if (cfg_ext > 32'(BUF_BYTES))       qb_cfg = (PW+1)'(BUF_BYTES);
      else                                     qb_cfg = (PW+1)'(cfg_ext);
   end

   // Queue control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         qb_ff       <= (PW+1)'(BUF_BYTES);
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fill_ptr_ff <= '0;
         count_ff    <= '0;
         pend_ff     <= '0;
      end else if (csr_valid) begin
         qb_ff       <= qb_cfg;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fill_ptr_ff <= '0;
         count_ff    <= '0;
         pend_ff     <= '0;
      end else begin
         if (cmd.hdr_accept) begin
            if (op_ff == vlmr_pkg::OP_URGENT) rd_ptr_ff <= urg_s[PW-1:0];
            else                              wr_ptr_ff <= wr_new_s[PW-1:0];
            fill_ptr_ff <= fill_new_s[PW-1:0];
            pend_ff     <= len_ff;
            count_ff    <= count_ff + 8'd1;
         end
         if (cmd.pay_write) begin
            fill_ptr_ff <= fill_next_s[PW-1:0];
            pend_ff     <= pend_ff - 6'd1;
         end
         if (cmd.remove) begin
            rd_ptr_ff <= after_s[PW-1:0];
            count_ff  <= count_ff - 8'd1;
         end
         if (cmd.read_begin) count_ff  <= count_ff - 8'd1;
         if (cmd.read_end)   rd_ptr_ff <= addr_ff;
      end
   end

   // Walking address and byte counter
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.hr_step;
      end
      rd_idx_ff <= cnt_ff[3:0];
      if (cmd.hdr_accept) begin
         addr_ff <= base_s[PW-1:0];
         cnt_ff  <= '0;
      end else if (cmd.hr_start) begin
         addr_ff <= rd_ptr_ff;
         cnt_ff  <= '0;
      end else if (cmd.read_begin) begin
         addr_ff <= start_s[PW-1:0];
         cnt_ff  <= '0;
      end else if (cmd.hw_step || cmd.hr_step || cmd.pr_step) begin
         addr_ff <= addr_next_s[PW-1:0];
         cnt_ff  <= cnt_ff + 6'd1;
      end
   end

   // Captured input word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= in_op;
         sender_ff <= in_sender_id;
         mid_ff    <= in_message_id;
         stamp_ff  <= in_stamp;
         len_ff    <= in_length;
         byte_ff   <= in_data_byte;
         maxlen_ff <= in_max_length;
      end
   end

   // Ring memory: one write port, one registered read port
   assign wr_en   = cmd.hw_step || cmd.pay_write;
   assign wr_addr = cmd.pay_write ? fill_ptr_ff : addr_ff;
   assign wr_data = cmd.pay_write ? byte_ff : hdr_byte;

   always_ff @(posedge clock) begin
      if (wr_en) ring_mem[wr_addr] <= wr_data;
      if (cmd.hr_step || cmd.pr_step) mem_q <= ring_mem[addr_ff];
   end

   // Head header bytes collected one a cycle
   always_ff @(posedge clock) begin
      if (rd_pend_ff) hdr_ff[rd_idx_ff] <= mem_q;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_status     <= cmd.emit_status;
         out_remaining  <= count_ff;
         out_sender     <= cmd.emit_head ? {hdr_ff[1], hdr_ff[0]} : '0;
         out_message_id <= cmd.emit_head ? {hdr_ff[5], hdr_ff[4], hdr_ff[3], hdr_ff[2]} : '0;
         out_stamp      <= cmd.emit_head ? {hdr_ff[13], hdr_ff[12], hdr_ff[11], hdr_ff[10],
                                            hdr_ff[9], hdr_ff[8], hdr_ff[7], hdr_ff[6]} : '0;
         out_length     <= cmd.emit_head ? hlen : '0;
         out_byte       <= cmd.emit_pay ? mem_q : '0;
         out_is_payload <= cmd.emit_pay;
         out_last       <= cmd.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

>>> sv/vlmr_checker.sv
// Port-level checks of the variable-length message ring and their binding.
`default_nettype none
module vlmr_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [135:0] rsp_tdata,
   input wire logic         rsp_tuser,
   input wire logic         rsp_tlast
);

   // A stalled result word holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // One word at a time: no acceptance right after an acceptance
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while a word is in work");

   // Payload words carry status ok
   a_pay_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[1:0] == 2'd0)
      else $error("payload word with error status");

   // A non-payload word carries a zero byte
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[135:128] == 8'd0)
      else $error("byte field set on a non-payload word");

   // An error result is the one and final word of its input
   a_unused_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && rsp_tdata[1:0] != 2'd0 |-> rsp_tlast)
      else $error("error result not final");

endmodule

bind variable_length_message_ring_core vlmr_checker u_vlmr_checker (.*);
`default_nettype wire

>>> bench/tb_variable_length_message_ring_core.sv
// Self-checking testbench of the variable-length message ring core.
`default_nettype none
module tb_variable_length_message_ring_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_SIZE = 4096;
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [1:0]  status;
      logic [7:0]  remaining;
      logic [15:0] sender;
      logic [31:0] msg_id;
      logic [63:0] stamp;
      logic [5:0]  length;
      logic [7:0]  data;
      logic        is_payload;
      logic        last;
   } rsp_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [12:0]  csr_data = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   // Shadow of the message ring
   logic [7:0]  ring_bytes [RING_SIZE];
   int unsigned ring_len;
   int unsigned wr_ptr, rd_ptr, fill_ptr, msg_count, bytes_pending;

   rsp_word_type pending_rsp [$];
   int          error_count = 0;
   int          words_sent = 0;
   int          words_checked = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          hold_off_cycles = 0;

   variable_length_message_ring_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always #4 clock = ~clock;

   // Ring pointer arithmetic within the configured size.
   function automatic int unsigned ring_adv(int unsigned p, int unsigned n);
      return (p + n) % ring_len;
   endfunction

   function automatic logic [7:0] ring_at(int unsigned p, int unsigned off);
      return ring_bytes[ring_adv(p, off)];
   endfunction

   // Queue the result word, with the head header when asked.
   task automatic push_rsp(logic [1:0] st, bit with_head, logic [7:0] data,
                           logic is_pay, logic last);
      rsp_word_type w;
      logic [7:0] len_byte;
      w = '{default: '0};
      w.status = st;
      w.remaining = msg_count[7:0];
      if (with_head) begin
         for (int i = 0; i < 2; i++) w.sender[8*i +: 8] = ring_at(rd_ptr, i);
         for (int i = 0; i < 4; i++) w.msg_id[8*i +: 8] = ring_at(rd_ptr, 2 + i);
         for (int i = 0; i < 8; i++) w.stamp[8*i +: 8] = ring_at(rd_ptr, 6 + i);
         len_byte = ring_at(rd_ptr, 14);
         w.length = len_byte[5:0];
      end
      w.data = data;
      w.is_payload = is_pay;
      w.last = last;
      pending_rsp.push_back(w);
   endtask

   task automatic store_header(int unsigned p, logic [15:0] snd, logic [31:0] mid,
                               logic [63:0] stp, logic [5:0] len);
      logic [191:0] hdr;
      hdr = '0;
      hdr[111:0] = {stp, mid, snd};
      hdr[119:112] = {2'b00, len};
      for (int i = 0; i < vlmr_pkg::HEAD_BYTES; i++)
         ring_bytes[ring_adv(p, i)] = hdr[8*i +: 8];
   endtask

   // Work out the results of one accepted word and update the shadow state.
   task automatic predict_ring(logic [2:0] op, logic [15:0] snd, logic [31:0] mid,
                               logic [63:0] stp, logic [5:0] len, logic [7:0] data,
                               logic [5:0] maxlen);
      int unsigned need, free_bytes, hlen, start;
      if (op == vlmr_pkg::OP_PAYLOAD) begin
         if (bytes_pending == 0) begin
            push_rsp(vlmr_pkg::ST_SIZE, 0, 0, 0, 1);
         end else begin
            ring_bytes[fill_ptr] = data;
            fill_ptr = ring_adv(fill_ptr, 1);
            bytes_pending--;
            push_rsp(vlmr_pkg::ST_OK, 0, 0, 0, 1);
         end
      end else if (op == OP_SPARE_LO || op == OP_SPARE_HI) begin
         push_rsp(vlmr_pkg::ST_OK, 0, 0, 0, 1);
      end else if (bytes_pending != 0) begin
         push_rsp(vlmr_pkg::ST_SIZE, 0, 0, 0, 1);
      end else if (op == vlmr_pkg::OP_APPEND || op == vlmr_pkg::OP_URGENT) begin
         need = vlmr_pkg::HEAD_BYTES + 32'(len);
         free_bytes = (rd_ptr > wr_ptr) ? rd_ptr - wr_ptr : ring_len - (wr_ptr - rd_ptr);
         if (free_bytes <= need || msg_count >= 32'(vlmr_pkg::MAX_COUNT)) begin
            push_rsp(vlmr_pkg::ST_OVERFLOW, 0, 0, 0, 1);
         end else begin
            if (op == vlmr_pkg::OP_APPEND) begin
               store_header(wr_ptr, snd, mid, stp, len);
               fill_ptr = ring_adv(wr_ptr, vlmr_pkg::HEAD_BYTES);
               wr_ptr = ring_adv(wr_ptr, need);
            end else begin
               rd_ptr = (rd_ptr + ring_len - need) % ring_len;
               store_header(rd_ptr, snd, mid, stp, len);
               fill_ptr = ring_adv(rd_ptr, vlmr_pkg::HEAD_BYTES);
            end
            bytes_pending = 32'(len);
            msg_count++;
            push_rsp(vlmr_pkg::ST_OK, 0, 0, 0, 1);
         end
      end else if (msg_count == 0) begin
         push_rsp(vlmr_pkg::ST_EMPTY, 0, 0, 0, 1);
      end else begin
         hlen = 32'(ring_at(rd_ptr, 14) & 8'h3f);
         start = ring_adv(rd_ptr, vlmr_pkg::HEAD_BYTES);
         if (op == vlmr_pkg::OP_PEEK) begin
            push_rsp(vlmr_pkg::ST_OK, 1, 0, 0, 1);
         end else if (op == vlmr_pkg::OP_REMOVE) begin
            rd_ptr = ring_adv(start, hlen);
            msg_count--;
            push_rsp(vlmr_pkg::ST_OK, 0, 0, 0, 1);
         end else if (32'(maxlen) < hlen) begin
            push_rsp(vlmr_pkg::ST_SIZE, 1, 0, 0, 1);
         end else begin
            msg_count--;
            push_rsp(vlmr_pkg::ST_OK, 1, 0, 0, hlen == 0);
            for (int i = 0; i < hlen; i++)
               push_rsp(vlmr_pkg::ST_OK, 1, ring_at(start, i), 1, i + 1 == hlen);
            rd_ptr = ring_adv(start, hlen);
         end
      end
   endtask

   task automatic clear_ring_state();
      wr_ptr = 0;
      rd_ptr = 0;
      fill_ptr = 0;
      msg_count = 0;
      bytes_pending = 0;
   endtask

   // Send one word, idling first as the current phase asks.
   task automatic send_word(logic [2:0] op, logic [15:0] snd, logic [31:0] mid,
                            logic [63:0] stp, logic [5:0] len, logic [7:0] data,
                            logic [5:0] maxlen);
      @(negedge clock);
      if (send_idle_pct > 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_tvalid = 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {4'h0, maxlen, data, len, stp, mid, snd};
      do @(posedge clock); while (!req_tready);
      predict_ring(op, snd, mid, stp, len, data, maxlen);
      words_sent++;
      // Valid drops at the next falling edge.
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_random_fields(logic [2:0] op, logic [5:0] len);
      send_word(op, 16'($urandom), $urandom, {$urandom, $urandom}, len, 8'($urandom),
                6'($urandom_range(63)));
   endtask

   // Wait for all expected results, then let the block settle.
   task automatic drain_results();
      wait (pending_rsp.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_queue_size(logic [12:0] value);
      drain_results();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      ring_len = (32'(value) < vlmr_pkg::MIN_QUEUE) ? vlmr_pkg::MIN_QUEUE :
                 (32'(value) > RING_SIZE) ? RING_SIZE : 32'(value);
      clear_ring_state();
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("error at %0t: %s got %0h, expected %0h", $realtime, field, got, want);
   endtask

   // Receiver: random stalls and the long hold-off.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result checker
   always @(posedge clock) begin
      rsp_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[63:0], 64'd0);
         end else begin
            w = pending_rsp.pop_front();
            words_checked++;
            if (rsp_tdata[1:0] !== w.status)
               report_mismatch("status", 64'(rsp_tdata[1:0]), 64'(w.status));
            if (rsp_tdata[9:2] !== w.remaining)
               report_mismatch("remaining", 64'(rsp_tdata[9:2]), 64'(w.remaining));
            if (rsp_tdata[25:10] !== w.sender)
               report_mismatch("sender", 64'(rsp_tdata[25:10]), 64'(w.sender));
            if (rsp_tdata[57:26] !== w.msg_id)
               report_mismatch("message id", 64'(rsp_tdata[57:26]), 64'(w.msg_id));
            if (rsp_tdata[121:58] !== w.stamp)
               report_mismatch("stamp", rsp_tdata[121:58], w.stamp);
            if (rsp_tdata[127:122] !== w.length)
               report_mismatch("length", 64'(rsp_tdata[127:122]), 64'(w.length));
            if (rsp_tdata[135:128] !== w.data)
               report_mismatch("payload byte", 64'(rsp_tdata[135:128]), 64'(w.data));
            if (rsp_tuser !== w.is_payload)
               report_mismatch("is_payload", 64'(rsp_tuser), 64'(w.is_payload));
            if (rsp_tlast !== w.last)
               report_mismatch("last", 64'(rsp_tlast), 64'(w.last));
         end
      end
   end

   // Directed: empty queue, stray payload, spare codes, open-write refusals,
   // small read buffer, urgent ordering and overflow of a minimum ring.
   task automatic test_directed();
      send_random_fields(vlmr_pkg::OP_PEEK, 0);
      send_random_fields(vlmr_pkg::OP_READ, 0);
      send_random_fields(vlmr_pkg::OP_REMOVE, 0);
      send_random_fields(vlmr_pkg::OP_PAYLOAD, 0);
      send_random_fields(OP_SPARE_LO, 0);
      send_random_fields(OP_SPARE_HI, 0);
      send_word(vlmr_pkg::OP_APPEND, 16'hffff, 32'hffffffff, 64'hffffffffffffffff, 6'd0,
                8'hff, 6'd63);
      send_word(vlmr_pkg::OP_APPEND, 16'h0000, 32'h0, 64'h0, 6'd3, 8'h00, 6'd0);
      send_random_fields(vlmr_pkg::OP_PEEK, 0);
      send_random_fields(vlmr_pkg::OP_READ, 0);
      send_random_fields(vlmr_pkg::OP_APPEND, 1);
      send_word(vlmr_pkg::OP_PAYLOAD, 0, 0, 0, 0, 8'hff, 0);
      send_word(vlmr_pkg::OP_PAYLOAD, 0, 0, 0, 0, 8'h00, 0);
      send_word(vlmr_pkg::OP_PAYLOAD, 0, 0, 0, 0, 8'ha5, 0);
      send_word(vlmr_pkg::OP_URGENT, 16'h1234, 32'h89abcdef, 64'h0123456789abcdef, 6'd2,
                0, 0);
      send_word(vlmr_pkg::OP_PAYLOAD, 0, 0, 0, 0, 8'h5a, 0);
      send_word(vlmr_pkg::OP_PAYLOAD, 0, 0, 0, 0, 8'h3c, 0);
      send_word(vlmr_pkg::OP_READ, 0, 0, 0, 0, 0, 6'd1);
      send_word(vlmr_pkg::OP_READ, 0, 0, 0, 0, 0, 6'd2);
      send_word(vlmr_pkg::OP_READ, 0, 0, 0, 0, 0, 6'd63);
      send_random_fields(vlmr_pkg::OP_REMOVE, 0);
      write_queue_size(13'd0);
      send_random_fields(vlmr_pkg::OP_APPEND, 6'd0);
      send_random_fields(vlmr_pkg::OP_APPEND, 6'd0);
      send_random_fields(vlmr_pkg::OP_URGENT, 6'd0);
   endtask

   // One random item: mostly well-formed messages, some noise.
   task automatic send_random_item();
      int pick;
      logic [5:0] len;
      pick = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(8));
      if (bytes_pending != 0 && pick < 88) send_random_fields(vlmr_pkg::OP_PAYLOAD, 0);
      else if (pick < 30) send_random_fields(vlmr_pkg::OP_APPEND, len);
      else if (pick < 45) send_random_fields(vlmr_pkg::OP_URGENT, len);
      else if (pick < 55) send_random_fields(vlmr_pkg::OP_PEEK, 0);
      else if (pick < 75) send_word(vlmr_pkg::OP_READ, 16'($urandom), $urandom,
                                    {$urandom, $urandom}, 0, 8'($urandom),
                                    ($urandom_range(3) == 0) ? 6'($urandom) : 6'd63);
      else if (pick < 90) send_random_fields(vlmr_pkg::OP_REMOVE, 0);
      else if (pick < 95) send_random_fields(vlmr_pkg::OP_PAYLOAD, 0);
      else send_random_fields($urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI, 0);
   endtask

   // Random traffic under the four idling phases and several ring sizes.
   task automatic test_random_phases();
      int idle [4] = '{0, 88, 0, 38};
      int stall [4] = '{0, 0, 88, 38};
      logic [12:0] size_sel [4] = '{13'd4096, 13'd8191, 13'd64, 13'd0};
      for (int ph = 0; ph < 4; ph++) begin
         write_queue_size(ph == 3 ? 13'($urandom_range(65, 400)) : size_sel[ph]);
         send_idle_pct = idle[ph];
         recv_stall_pct = stall[ph];
         repeat (45) send_random_item();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   // Long receiver hold-off while words keep coming, so the input stalls.
   task automatic test_backpressure();
      write_queue_size(13'd1000);
      hold_off_cycles = 400;
      repeat (20) send_random_item();
      send_random_fields(vlmr_pkg::OP_READ, 0);
   endtask

   initial begin
      ring_len = RING_SIZE;
      clear_ring_state();
      for (int i = 0; i < RING_SIZE; i++) ring_bytes[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_phases();
      test_backpressure();
      drain_results();
      $display("Sent %0d words and checked %0d result words across several ring sizes,",
               words_sent, words_checked);
      $display("with sender gaps, receiver stalls and a long receiver hold-off.");
      if (error_count == 0) $display("variable_length_message_ring_core: match");
      else $display("variable_length_message_ring_core: mismatch");
      $finish;
   end

   // Overall time limit
   initial begin
      #20ms;
      $display("variable_length_message_ring_core: mismatch");
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
sv/vlmr_pkg.sv
sv/vlmr_ctrl.sv
sv/vlmr_dpath.sv
sv/variable_length_message_ring_core.sv
sv/vlmr_checker.sv
bench/tb_variable_length_message_ring_core.sv
